[rtl/psg_pkg.sv]
// shared types and constants of the partition segmenter
`default_nettype none

package psg_pkg;

  localparam int AlphabetSize = 26;
  localparam int LengthBits   = 16;
  localparam int LetterW      = 5;
  localparam int PartW        = 16;

  // input word: one letter or the end of the string
  typedef struct packed {
    logic [LetterW-1:0] letter;
    logic               end_of_string;
  } item_t;

  // output word: one partition length
  typedef struct packed {
    logic [PartW-1:0] part_length;
    logic             last_part;
  } result_t;

  // stack operation requested by the controller
  typedef struct packed {
    logic push;
    logic bump;
    logic pop;
    logic drop;
  } stack_cmd_t;

  // per-cell operation
  typedef struct packed {
    logic push;
    logic merge;
    logic shift_up;
    logic bump;
    logic drop;
  } cell_cmd_t;

  // stack status seen by the controller
  typedef struct packed {
    logic hit_any;
    logic hit_top;
    logic any_valid;
    logic bottom_last;
  } stack_status_t;

endpackage

`default_nettype wire

[rtl/psg_cell.sv]
// one stack cell: a segment's letter set and length
`default_nettype none

module psg_cell #(
  parameter int ALPHABET_SIZE = psg_pkg::AlphabetSize,
  parameter int LENGTH_BITS   = psg_pkg::LengthBits
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire psg_pkg::cell_cmd_t       cmd,
  input  wire logic                     up_valid,
  input  wire logic [ALPHABET_SIZE-1:0] up_mask,
  input  wire logic [LENGTH_BITS-1:0]   up_len,
  input  wire logic                     down_valid,
  input  wire logic [ALPHABET_SIZE-1:0] down_mask,
  input  wire logic [LENGTH_BITS-1:0]   down_len,
  output logic                          valid,
  output logic [ALPHABET_SIZE-1:0]      mask,
  output logic [LENGTH_BITS-1:0]        len,
  output logic                          is_bottom
);

  logic [LENGTH_BITS-1:0] addend;
  logic [LENGTH_BITS:0]   sum;
  logic [LENGTH_BITS-1:0] sat_sum;

  assign is_bottom = valid && !down_valid;

  // saturating add for merge and for the repeated-letter increment
  always_comb begin
    addend  = cmd.merge ? down_len : LENGTH_BITS'(1);
    sum     = {1'b0, len} + {1'b0, addend};
    sat_sum = sum[LENGTH_BITS] ? {LENGTH_BITS{1'b1}} : sum[LENGTH_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      priority if (cmd.push) begin
        valid <= up_valid;
      end else if (cmd.shift_up) begin
        valid <= down_valid;
      end else if (cmd.drop && is_bottom) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (cmd.push) begin
      mask <= up_mask;
      len  <= up_len;
    end else if (cmd.merge) begin
      mask <= mask | down_mask;
      len  <= sat_sum;
    end else if (cmd.shift_up) begin
      mask <= down_mask;
      len  <= down_len;
    end else if (cmd.bump) begin
      len  <= sat_sum;
    end
  end

endmodule

`default_nettype wire

[rtl/psg_stack.sv]
// chain of segment cells, top of stack at cell zero
`default_nettype none

module psg_stack #(
  parameter int ALPHABET_SIZE = psg_pkg::AlphabetSize,
  parameter int LENGTH_BITS   = psg_pkg::LengthBits
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire psg_pkg::stack_cmd_t      cmd,
  input  wire logic [ALPHABET_SIZE-1:0] new_mask,
  output psg_pkg::stack_status_t        status,
  output logic [LENGTH_BITS-1:0]        bottom_len
);

  logic [ALPHABET_SIZE-1:0] valid;
  logic [ALPHABET_SIZE-1:0] bottom;
  logic [ALPHABET_SIZE-1:0] hit;
  logic [ALPHABET_SIZE-1:0] mask [ALPHABET_SIZE];
  logic [LENGTH_BITS-1:0]   len  [ALPHABET_SIZE];
  logic [LENGTH_BITS-1:0]   sel_len [ALPHABET_SIZE];

  for (genvar i = 0; i < ALPHABET_SIZE; i++) begin : g_cell
    psg_pkg::cell_cmd_t       ccmd;
    logic                     up_valid;
    logic [ALPHABET_SIZE-1:0] up_mask;
    logic [LENGTH_BITS-1:0]   up_len;
    logic                     down_valid;
    logic [ALPHABET_SIZE-1:0] down_mask;
    logic [LENGTH_BITS-1:0]   down_len;

    if (i == 0) begin : g_head
      // head takes the new segment on push and absorbs its neighbor on pop
      assign up_valid      = 1'b1;
      assign up_mask       = new_mask;
      assign up_len        = LENGTH_BITS'(1);
      assign ccmd.merge    = cmd.pop;
      assign ccmd.shift_up = 1'b0;
      assign ccmd.bump     = cmd.bump;
    end else begin : g_body
      assign up_valid      = valid[i-1];
      assign up_mask       = mask[i-1];
      assign up_len        = len[i-1];
      assign ccmd.merge    = 1'b0;
      assign ccmd.shift_up = cmd.pop;
      assign ccmd.bump     = 1'b0;
    end

    if (i == ALPHABET_SIZE - 1) begin : g_tail
      assign down_valid = 1'b0;
      assign down_mask  = '0;
      assign down_len   = '0;
    end else begin : g_link
      assign down_valid = valid[i+1];
      assign down_mask  = mask[i+1];
      assign down_len   = len[i+1];
    end

    assign ccmd.push = cmd.push;
    assign ccmd.drop = cmd.drop;

    psg_cell #(
      .ALPHABET_SIZE(ALPHABET_SIZE),
      .LENGTH_BITS  (LENGTH_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (ccmd),
      .up_valid  (up_valid),
      .up_mask   (up_mask),
      .up_len    (up_len),
      .down_valid(down_valid),
      .down_mask (down_mask),
      .down_len  (down_len),
      .valid     (valid[i]),
      .mask      (mask[i]),
      .len       (len[i]),
      .is_bottom (bottom[i])
    );

    assign hit[i]     = valid[i] && (|(mask[i] & new_mask));
    assign sel_len[i] = bottom[i] ? len[i] : '0;
  end

  // and-or select of the bottom cell, which is one-hot
  always_comb begin
    bottom_len = '0;
    for (int i = 0; i < ALPHABET_SIZE; i++) begin
      bottom_len = bottom_len | sel_len[i];
    end
  end

  assign status.hit_any     = |hit;
  assign status.hit_top     = hit[0];
  assign status.any_valid   = valid[0];
  assign status.bottom_last = bottom[0];

endmodule

`default_nettype wire

[rtl/partition_labels_segmenter_core.sv]
// top level of the partition segmenter: control, letter decode, output register
//
// usage
//   item channel: one word per letter (letter 0..25) or an end word
//   (end_of_string = 1, letter ignored). letters outside the alphabet are
//   taken and dropped. result channel: on an end word the block sends one
//   word per partition, first partition first, last_part set on the final one.
// processing
//   a letter is accepted, then looked up in the cell chain; a repeated
//   letter folds its segment and every open segment above it into one,
//   each fold moving one cell's contents into its neighbor. every segment
//   is folded at most once. no new item is taken until the current one is
//   done. an end word is accepted, then for each partition the bottom cell
//   of the chain is read and released, and the flush ends on finding the
//   chain empty; the first release loads the first result into the output
//   register.
// reset
//   rst clears all cell valid bits, the state machine and the output valid
//   bit; a new string can start at the next cycle.
// stall
//   a stalled result holds in the output register and the flush waits behind
//   it; once the last partition sits in the register, letters of the next
//   string are accepted even while it stalls.
`default_nettype none

module partition_labels_segmenter_core #(
  parameter int ALPHABET_SIZE = psg_pkg::AlphabetSize,
  parameter int LENGTH_BITS   = psg_pkg::LengthBits
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_stall,
  input  wire psg_pkg::item_t   item,
  output logic                  result_valid,
  input  wire logic             result_stall,
  output psg_pkg::result_t      result
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_LOOK  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  state_t state, state_next;

  logic                         accept;
  logic [ALPHABET_SIZE-1:0]     onehot;
  logic [ALPHABET_SIZE-1:0]     letter_mask;
  psg_pkg::stack_cmd_t          cmd;
  psg_pkg::stack_status_t       status;
  logic [LENGTH_BITS-1:0]       bottom_len;
  logic                         out_load;
  logic [psg_pkg::PartW+LENGTH_BITS-1:0] len_wide;

  assign item_stall = (state != ST_IDLE);
  assign accept     = item_valid && !item_stall;

  // letter decode; codes past the alphabet give an empty mask
  for (genvar j = 0; j < ALPHABET_SIZE; j++) begin : g_dec
    if (j < (2 ** psg_pkg::LetterW)) begin : g_hit
      assign onehot[j] = (item.letter == psg_pkg::LetterW'(j));
    end else begin : g_none
      assign onehot[j] = 1'b0;
    end
  end

  // held letter for the cycles spent in the chain
  always_ff @(posedge clk) begin
    if (accept) begin
      letter_mask <= onehot;
    end
  end

  // output register frees up when empty or taken this cycle
  assign out_load = !result_valid || !result_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (item.end_of_string) begin
            state_next = ST_FLUSH;
          end else if (|onehot) begin
            state_next = ST_LOOK;
          end
        end
      end
      ST_LOOK: begin
        // new letter opens a segment, a letter of the top segment lengthens
        // it, otherwise fold the segment below into the top one and retry
        priority if (!status.hit_any) begin
          cmd.push   = 1'b1;
          state_next = ST_IDLE;
        end else if (status.hit_top) begin
          cmd.bump   = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cmd.pop    = 1'b1;
        end
      end
      ST_FLUSH: begin
        if (!status.any_valid) begin
          state_next = ST_IDLE;
        end else if (out_load) begin
          cmd.drop = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  psg_stack #(
    .ALPHABET_SIZE(ALPHABET_SIZE),
    .LENGTH_BITS  (LENGTH_BITS)
  ) u_stack (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .new_mask  (letter_mask),
    .status    (status),
    .bottom_len(bottom_len)
  );

  // length to the output field width
  assign len_wide = {{psg_pkg::PartW{1'b0}}, bottom_len};

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= cmd.drop;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.drop) begin
      result.part_length <= len_wide[psg_pkg::PartW-1:0];
      result.last_part   <= status.bottom_last;
    end
  end

endmodule

`default_nettype wire

[rtl/psg_checker.sv]
// port checker for the partition segmenter and its bind
`default_nettype none

module psg_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             item_valid,
  input wire logic             item_stall,
  input wire psg_pkg::item_t   item,
  input wire logic             result_valid,
  input wire logic             result_stall,
  input wire psg_pkg::result_t result
);

  // stalled result word holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result word changed");

  // the input always stalls after an end word, in the flush state
  a_end_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && item.end_of_string |=> item_stall)
    else $error("input taken right after end word");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  // partitions of one string go out back to back
  a_flush_gapless: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && !result.last_part |=> result_valid)
    else $error("gap inside a partition list");

endmodule

bind partition_labels_segmenter_core psg_checker u_psg_checker (
  .clk         (clk),
  .rst         (rst),
  .item_valid  (item_valid),
  .item_stall  (item_stall),
  .item        (item),
  .result_valid(result_valid),
  .result_stall(result_stall),
  .result      (result)
);

`default_nettype wire
